@@ src/timer_heap_scheduler_assert.svh @@
// Assertion macros used by the checker file
`ifndef TIMER_HEAP_SCHEDULER_ASSERT_SVH
`define TIMER_HEAP_SCHEDULER_ASSERT_SVH
// implication checked on every clock edge outside reset
`define THS_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// implication checked with the consequent in the next cycle
`define THS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

@@ src/ths_pkg.sv @@
// ----------------------------------------------------------------------------
// ths_pkg
// Types and constants for the timer queue.
// ----------------------------------------------------------------------------
`default_nettype none
package ths_pkg;
  localparam int TIMER_SLOTS = 32;
  localparam int MAX_RESULTS = 32;
  localparam int SLOT_W      = $clog2(TIMER_SLOTS);
  localparam int CNT_W       = $clog2(TIMER_SLOTS + 1);
  localparam int RES_W       = $clog2(MAX_RESULTS + 1);
  localparam int ENTRY_W     = 48 + 32 + 32;

  typedef enum logic [1:0] {
    REQ_CREATE = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_TICK   = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    RES_CREATED  = 2'd0,
    RES_EXPIRED  = 2'd1,
    RES_REJECTED = 2'd2
  } kind_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] delay_ms;
    logic [31:0] source_tag;
    logic [31:0] target_id;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [31:0] result_id;
    logic [47:0] expiry_time;
    logic [31:0] owner_tag;
    logic        last;
  } out_word_t;

  typedef struct packed {
    logic [47:0] expiry;
    logic [31:0] ident;
    logic [31:0] owner;
  } entry_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DEL_RD,
    ST_DEL_CHK,
    ST_MV_WAIT,
    ST_MV_WR,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_EMIT,
    ST_OUT,
    ST_FIN
  } state_t;
endpackage
`default_nettype wire

@@ src/ths_ram.sv @@
// ----------------------------------------------------------------------------
// ths_ram
// Generic RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none
module ths_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ src/timer_heap_scheduler.sv @@
// ----------------------------------------------------------------------------
// timer_heap_scheduler
// Timer queue with create, delete and millisecond tick requests.
// ----------------------------------------------------------------------------
// Usage: requests arrive on in_valid/in_ready as in_word_t, results leave on
// out_valid/out_ready as out_word_t. A create answers one word in the cycle
// after acceptance. A delete walks all live entries, refilling each removed
// slot from the last entry, and answers nothing. A tick scans all live
// entries through the one memory read port, again after each expiry, until a
// scan finds no expired timer or MAX_RESULTS timers have expired. Each expired
// word is held back until the next scan shows whether it closes the tick, then
// moves to the output register, where it holds until taken; a stalled
// receiver stalls the scan. One item is processed at a time: in_ready is high
// only when idle with no word pending. Reset clears the count, the clock and
// the id counter; the entry memory needs no clearing since only entries below
// the count are used.
// ----------------------------------------------------------------------------
`default_nettype none
module timer_heap_scheduler
  import ths_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_word_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_word_t      out_data
);
  state_t             state, state_next;
  in_word_t           req;
  logic [CNT_W-1:0]   live_count;
  logic [47:0]        clock_ms;
  logic [31:0]        next_ident;
  logic [CNT_W-1:0]   idx;
  logic [RES_W-1:0]   emitted;
  logic               found;
  logic [SLOT_W-1:0]  best_idx;
  entry_t             best;
  logic [SLOT_W-1:0]  hole;
  out_word_t          held;
  out_word_t          out_next;
  logic               load_out;

  logic               we;
  logic [SLOT_W-1:0]  waddr, raddr;
  entry_t             wdata, rdata;

  ths_ram #(.WIDTH(ENTRY_W), .DEPTH(TIMER_SLOTS)) u_ram (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  logic accept;
  assign accept   = in_valid && in_ready;
  assign in_ready = (state == ST_IDLE) && !out_valid;

  logic out_free;
  assign out_free = !out_valid || out_ready;

  logic [CNT_W-1:0] last_slot;
  assign last_slot = live_count - CNT_W'(1);

  logic better;
  assign better = (rdata.expiry <= clock_ms) && (!found ||
                  rdata.expiry < best.expiry ||
                  (rdata.expiry == best.expiry && rdata.ident < best.ident));

  logic full;
  assign full = (live_count >= CNT_W'(TIMER_SLOTS));

  logic [47:0] new_exp;
  assign new_exp = clock_ms + {16'd0, in_data.delay_ms};

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          priority if (in_data.req_type == REQ_DELETE) state_next = ST_DEL_RD;
          else if (in_data.req_type == REQ_TICK) state_next = ST_SCAN_RD;
          else state_next = ST_IDLE;
        end
      end
      ST_DEL_RD:  state_next = (idx < live_count) ? ST_DEL_CHK : ST_IDLE;
      ST_DEL_CHK: state_next = (rdata.ident == req.target_id) ? ST_MV_WAIT : ST_DEL_RD;
      ST_MV_WAIT: state_next = ST_MV_WR;
      ST_MV_WR:   state_next = (req.req_type == REQ_DELETE) ? ST_DEL_RD : ST_FIN;
      ST_SCAN_RD: begin
        if (emitted >= RES_W'(MAX_RESULTS)) state_next = ST_OUT;
        else if (idx < live_count) state_next = ST_SCAN_CHK;
        else state_next = found ? ST_EMIT : ST_OUT;
      end
      ST_SCAN_CHK: state_next = ST_SCAN_RD;
      ST_EMIT:     state_next = (emitted == '0 || out_free) ? ST_MV_WAIT : ST_EMIT;
      ST_FIN:      state_next = ST_SCAN_RD;
      ST_OUT:      state_next = (emitted == '0 || out_free) ? ST_IDLE : ST_OUT;
      default:     state_next = ST_IDLE;
    endcase
  end

  // output word selection
  always_comb begin
    load_out = 1'b0;
    out_next = held;
    unique case (state)
      ST_IDLE: begin
        load_out = accept && (in_data.req_type == REQ_CREATE);
        if (full) begin
          out_next = '{RES_REJECTED, 32'd0, 48'd0, 32'd0, 1'b1};
        end else begin
          out_next = '{RES_CREATED, next_ident, new_exp, in_data.source_tag, 1'b1};
        end
      end
      ST_EMIT: load_out = (emitted != '0) && out_free;
      ST_OUT: begin
        load_out      = (emitted != '0) && out_free;
        out_next.last = 1'b1;
      end
      default: ;
    endcase
  end

  // memory port control
  always_comb begin
    we    = 1'b0;
    waddr = SLOT_W'(live_count);
    wdata = '{expiry: new_exp, ident: next_ident, owner: in_data.source_tag};
    raddr = idx[SLOT_W-1:0];
    unique case (state)
      ST_IDLE:    we = accept && (in_data.req_type == REQ_CREATE) && !full;
      ST_MV_WAIT: raddr = last_slot[SLOT_W-1:0];
      ST_MV_WR: begin
        we    = 1'b1;
        waddr = hole;
        wdata = rdata;
      end
      default: ;
    endcase
  end

  // registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      live_count <= '0;
      clock_ms   <= '0;
      next_ident <= '0;
      out_valid  <= 1'b0;
      found      <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= load_out || (out_valid && !out_ready);
      if (load_out) out_data <= out_next;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            req     <= in_data;
            idx     <= '0;
            emitted <= '0;
            found   <= 1'b0;
            if (in_data.req_type == REQ_CREATE && !full) begin
              live_count <= live_count + CNT_W'(1);
              next_ident <= next_ident + 32'd1;
            end
            if (in_data.req_type == REQ_TICK) clock_ms <= clock_ms + 48'd1;
          end
        end
        ST_DEL_RD: idx <= idx + CNT_W'(1);
        ST_DEL_CHK: begin
          if (rdata.ident == req.target_id) begin
            hole <= SLOT_W'(idx - CNT_W'(1));
            idx  <= idx - CNT_W'(1);
          end
        end
        ST_MV_WR: live_count <= last_slot;
        ST_SCAN_RD: idx <= idx + CNT_W'(1);
        ST_SCAN_CHK: begin
          if (better) begin
            found    <= 1'b1;
            best     <= rdata;
            best_idx <= SLOT_W'(idx - CNT_W'(1));
          end
        end
        // hold the new expiry until the next scan decides its last flag
        ST_EMIT: begin
          if (emitted == '0 || out_free) begin
            held    <= '{RES_EXPIRED, best.ident, best.expiry, best.owner, 1'b0};
            emitted <= emitted + RES_W'(1);
            hole    <= best_idx;
          end
        end
        ST_FIN: begin
          idx   <= '0;
          found <= 1'b0;
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ src/ths_checker.sv @@
// ----------------------------------------------------------------------------
// ths_checker
// Port-level checks for the timer queue, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "timer_heap_scheduler_assert.svh"
module ths_checker
  import ths_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire in_word_t  in_data,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_word_t out_data
);
  // a create word answers in the following cycle
  `THS_ASSERT_NEXT(a_create_answer, clk, rst,
    in_valid && in_ready && in_data.req_type == REQ_CREATE, out_valid,
    "create produced no word")
  // created and rejected words always close their item
  `THS_ASSERT_IMPL(a_create_last, clk, rst,
    out_valid && out_data.result_kind != RES_EXPIRED, out_data.last,
    "create word without last")
  // no new request while a word is pending
  `THS_ASSERT_IMPL(a_no_overlap, clk, rst, out_valid, !in_ready,
    "input ready with word pending")
  // stalled output word holds
  `THS_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready,
    out_valid && $stable(out_data), "output word changed while stalled")
endmodule

bind timer_heap_scheduler ths_checker u_ths_checker (
  .clk, .rst, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data
);
`default_nettype wire

@@ bench/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives create, delete and tick requests into the timer queue and checks
// every result word against an in-bench model of the timer set.
// ----------------------------------------------------------------------------
`default_nettype none

class timer_ledger;
  logic [47:0] slot_exp[$];
  logic [31:0] slot_id[$];
  logic [31:0] slot_tag[$];
  logic [47:0] now_ms;
  logic [31:0] id_next;
  ths_pkg::out_word_t pending[$];
  int errors;
  int n_created, n_expired, n_rejected;

  function new();
    now_ms = '0;
    id_next = '0;
    errors = 0;
    n_created = 0;
    n_expired = 0;
    n_rejected = 0;
  endfunction

  // work out the words one request causes and queue them
  function void note_request(ths_pkg::in_word_t w);
    ths_pkg::out_word_t r;
    int best;
    int i;
    int n;
    r = '0;
    case (w.req_type)
      ths_pkg::REQ_CREATE: begin
        if (slot_id.size() >= ths_pkg::TIMER_SLOTS) begin
          r.result_kind = ths_pkg::RES_REJECTED;
        end else begin
          r.result_kind = ths_pkg::RES_CREATED;
          r.result_id = id_next;
          r.expiry_time = now_ms + {16'd0, w.delay_ms};
          r.owner_tag = w.source_tag;
          slot_exp.insert(slot_exp.size(), r.expiry_time);
          slot_id.insert(slot_id.size(), id_next);
          slot_tag.insert(slot_tag.size(), w.source_tag);
          id_next = id_next + 1;
        end
        r.last = 1'b1;
        pending.insert(pending.size(), r);
      end
      ths_pkg::REQ_DELETE: begin
        i = 0;
        while (i < slot_id.size()) begin
          if (slot_id[i] == w.target_id) begin
            slot_exp.delete(i);
            slot_id.delete(i);
            slot_tag.delete(i);
          end else begin
            i++;
          end
        end
      end
      ths_pkg::REQ_TICK: begin
        now_ms = now_ms + 1;
        n = 0;
        while (n < ths_pkg::MAX_RESULTS) begin
          best = -1;
          for (i = 0; i < slot_id.size(); i++) begin
            if (slot_exp[i] <= now_ms && (best < 0 || slot_exp[i] < slot_exp[best] ||
                (slot_exp[i] == slot_exp[best] && slot_id[i] < slot_id[best])))
              best = i;
          end
          if (best < 0) break;
          r = '0;
          r.result_kind = ths_pkg::RES_EXPIRED;
          r.result_id = slot_id[best];
          r.expiry_time = slot_exp[best];
          r.owner_tag = slot_tag[best];
          pending.insert(pending.size(), r);
          slot_exp.delete(best);
          slot_id.delete(best);
          slot_tag.delete(best);
          n++;
        end
        if (n > 0) pending[pending.size() - 1].last = 1'b1;
      end
      default: ;
    endcase
  endfunction

  // compare one result word with the oldest expectation
  function void check_result(ths_pkg::out_word_t got);
    ths_pkg::out_word_t want;
    if (pending.size() == 0) begin
      $display("%0t unexpected word %h", $time, got);
      errors++;
      return;
    end
    want = pending.pop_front();
    case (got.result_kind)
      ths_pkg::RES_CREATED:  n_created++;
      ths_pkg::RES_EXPIRED:  n_expired++;
      default:               n_rejected++;
    endcase
    if (got.result_kind !== want.result_kind) begin
      $display("%0t result_kind exp %0d got %0d", $time, want.result_kind, got.result_kind);
      errors++;
    end
    if (got.result_id !== want.result_id) begin
      $display("%0t result_id exp %h got %h", $time, want.result_id, got.result_id);
      errors++;
    end
    if (got.expiry_time !== want.expiry_time) begin
      $display("%0t expiry_time exp %h got %h", $time, want.expiry_time, got.expiry_time);
      errors++;
    end
    if (got.owner_tag !== want.owner_tag) begin
      $display("%0t owner_tag exp %h got %h", $time, want.owner_tag, got.owner_tag);
      errors++;
    end
    if (got.last !== want.last) begin
      $display("%0t last exp %b got %b", $time, want.last, got.last);
      errors++;
    end
  endfunction
endclass

module tb;
  import ths_pkg::*;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_word_t out_data;

  timer_ledger ledger;
  bit          send_done;

  timer_heap_scheduler i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // hold one word on the input until it is taken
  task automatic send_word(in_word_t w);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    ledger.note_request(w);
  endtask

  task automatic send_req(req_t kind, logic [31:0] dly, logic [31:0] tag, logic [31:0] tgt);
    in_word_t w;
    w.req_type   = kind;
    w.delay_ms   = dly;
    w.source_tag = tag;
    w.target_id  = tgt;
    send_word(w);
  endtask

  // drop valid and wait until every expected word is back
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (ledger.pending.size() > 0) @(posedge clk);
  endtask

  // pick a target id: mostly a live one, sometimes a stale or random id
  function automatic logic [31:0] pick_target();
    int p;
    p = $urandom_range(0, 9);
    if (p < 7 && ledger.slot_id.size() > 0)
      return ledger.slot_id[$urandom_range(0, ledger.slot_id.size() - 1)];
    if (p < 9) return ledger.id_next - $urandom_range(1, 8);
    return $urandom();
  endfunction

  // drain results with random stalls
  initial begin
    int g;
    out_ready = 1'b0;
    @(negedge rst);
    forever begin
      g = gap_len();
      if ($urandom_range(0, 3) == 0) g = 0;
      out_ready <= (g == 0);
      repeat ((g == 0) ? 1 : g) begin
        @(posedge clk);
        if (out_valid && out_ready) ledger.check_result(out_data);
      end
    end
  end

  initial begin
    int i;
    int k;
    int p;
    ledger    = new();
    send_done = 0;
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: zero and maximum delay, maximal tags, unknown delete, idle tick
    send_req(REQ_CREATE, 32'd0, 32'hFFFF_FFFF, 32'd0);
    send_req(REQ_CREATE, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
    send_req(REQ_CREATE, 32'd1, 32'hA5A5_5A5A, 32'd0);
    send_req(REQ_CREATE, 32'd1, 32'h5A5A_A5A5, 32'd0);
    send_req(REQ_DELETE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_req(REQ_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_req(REQ_TICK, 32'd0, 32'd0, 32'd0);
    send_req(REQ_DELETE, 32'd0, 32'd0, 32'd1);
    send_req(REQ_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_req(REQ_TICK, 32'd0, 32'd0, 32'd0);
    // fill the queue to the top and push one more
    for (i = 0; i < TIMER_SLOTS; i++)
      send_req(REQ_CREATE, 32'd2, $urandom(), 32'd0);
    send_req(REQ_CREATE, 32'd5, 32'h1234_5678, 32'd0);
    // hold off until every word is back
    wait_drained();
    // all slots due on one tick: a full burst of expiries
    send_req(REQ_TICK, 32'd0, 32'd0, 32'd0);
    send_req(REQ_TICK, 32'd0, 32'd0, 32'd0);

    // random traffic with a bias toward short delays
    for (i = 0; i < 225; i++) begin
      p = $urandom_range(0, 99);
      if (p < 45) begin
        k = $urandom_range(0, 9);
        send_req(REQ_CREATE,
                 (k == 0) ? $urandom() : (k == 1) ? 32'hFFFF_FFFF : $urandom_range(0, 12),
                 $urandom(), $urandom());
      end else if (p < 60) begin
        send_req(REQ_DELETE, $urandom(), $urandom(), pick_target());
      end else if (p < 97) begin
        send_req(REQ_TICK, $urandom(), $urandom(), $urandom());
      end else begin
        send_req(REQ_NONE, $urandom(), $urandom(), $urandom());
      end
    end
    in_valid  <= 1'b0;
    send_done = 1;
  end

  // close the run once everything is back
  initial begin
    wait (send_done);
    while (ledger.pending.size() > 0) @(posedge clk);
    repeat (400) @(posedge clk);
    $display("created %0d, expired %0d, rejected %0d, final clock %0d ms",
             ledger.n_created, ledger.n_expired, ledger.n_rejected, ledger.now_ms);
    $display("timers left queued at end: %0d", ledger.slot_id.size());
    if (ledger.errors == 0 && ledger.pending.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog
  initial begin
    #100ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

`default_nettype wire

@@ timer_heap_scheduler.f @@
+incdir+src
src/ths_pkg.sv
src/ths_ram.sv
src/timer_heap_scheduler.sv
src/ths_checker.sv
bench/tb.sv
